FILE: hdl/first_fit_heap_allocator_defines.svh
// Assertion macros shared by the checker of the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define FFHA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define FFHA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/ffha_pkg.sv
// Shared constants, types and codes of the first-fit heap allocator.
package ffha_pkg;
	localparam int MAX_BLOCKS = 64;
	localparam int HDR_BYTES  = 12;
	localparam int PAY_W      = 20;
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int MIN_SPLIT  = HDR_BYTES + 4;

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_RESIZE  = 2'd2;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_NOSPACE = 2'd1;
	localparam logic [1:0] STS_BADADDR = 2'd2;
	localparam logic [1:0] STS_ZERO    = 2'd3;

	typedef struct packed {
		logic             free;
		logic [PAY_W-1:0] pay;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic pop;
		logic push;
	} chain_ctl_t;

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_MOD, S_FLUSH, S_DONE
	} state_t;
endpackage

FILE: hdl/ffha_cell.sv
// One slot of the block table: holds an entry, loads it or takes its right neighbor's.
module ffha_cell import ffha_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  logic   load,
	input  entry_t load_data,
	input  entry_t right_data,
	output entry_t data
);
	entry_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (load) begin
			data_q <= load_data;
		end else if (shift) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;
endmodule

FILE: hdl/ffha_chain.sv
// Row of table cells working as a queue: pop shifts toward the head, push fills the tail.
module ffha_chain import ffha_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  chain_ctl_t       ctl,
	input  entry_t           push_data,
	output entry_t           head,
	output logic [CNT_W-1:0] count
);
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] wr;
	entry_t           cell_out [MAX_BLOCKS];

	// The tail position after this cycle's pop.
	assign wr = ctl.clear ? '0 : count_q - CNT_W'(ctl.pop);

	for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
		entry_t right;
		if (k == MAX_BLOCKS - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid
			assign right = cell_out[k+1];
		end
		ffha_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (ctl.pop),
			.load       (ctl.push && (wr == CNT_W'(k))),
			.load_data  (push_data),
			.right_data (right),
			.data       (cell_out[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= CNT_W'(ctl.push);
		end else begin
			count_q <= count_q - CNT_W'(ctl.pop) + CNT_W'(ctl.push);
		end
	end

	assign head  = cell_out[0];
	assign count = count_q;
endmodule

FILE: hdl/first_fit_heap_allocator.sv
// A search pass rotates all N entries of the table through the head; when the table changes, a
// rewrite pass then moves them again while splitting, marking and merging, and a split adds a
// step that pushes the remainder block. A new request is taken while the last result still
// waits at the output; the next result is held in the done state until the output is free.
// After reset, and after each register write, the heap is rebuilt as one free block, or as an
// empty table when the heap is too small to hold one.
module first_fit_heap_allocator import ffha_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // req_bytes[31:0], address[63:32]
	input  logic [1:0]   s_axis_tuser,  // action[1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [87:0]  m_axis_tdata,  // result_address[31:0], copy_bytes[51:32],
	                                    // old_address[83:52], zero fill[87:84]
	output logic [1:0]   m_axis_tuser,  // status[1:0]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	state_t state_q, state_n;

	logic [31:0]      heap_base_q;
	logic [PAY_W-1:0] heap_bytes_q;
	logic [31:0]      origin_q;

	logic [1:0]       act_q;
	logic [31:0]      req_q, addr_q;
	logic [PAY_W-1:0] r_q;
	logic             r_ok_q;

	logic [CNT_W-1:0] n_blk_q, k_q;
	logic [31:0]      run_q;
	logic             fo_q, fn_q;
	logic [CNT_W-1:0] o_idx_q, n_idx_q, split_idx_q;
	logic [PAY_W-1:0] o_pay_q;
	logic [31:0]      n_addr_q;

	logic [1:0]       sts_q;
	logic [31:0]      res_q, old_q;
	logic [PAY_W-1:0] copy_q;
	logic             do_split_q, do_use_q, do_free_q, coal_q;

	logic             pend_q, acc_v_q;
	logic [PAY_W-1:0] rem_q;
	entry_t           acc_q;

	logic             m_valid_q;
	logic [1:0]       m_user_q;
	logic [87:0]      m_data_q;

	chain_ctl_t       ctl;
	entry_t           push_data, head;
	logic [CNT_W-1:0] count;

	ffha_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.push_data (push_data),
		.head      (head),
		.count     (count)
	);

	logic cfg_fire, in_fire, out_free;
	assign cfg_ready     = (state_q == S_IDLE);
	assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_fire      = cfg_valid && cfg_ready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// Heap rebuild from the two registers.
	logic [1:0]       adj;
	logic [PAY_W-1:0] eff_raw, eff;
	logic             init_ok;
	entry_t           init_entry;
	assign adj        = ~heap_base_q[1:0] + 2'd1;
	assign eff_raw    = heap_bytes_q - PAY_W'(adj);
	assign eff        = (heap_bytes_q >= PAY_W'(adj)) ? {eff_raw[PAY_W-1:2], 2'b00} : '0;
	assign init_ok    = eff >= PAY_W'(MIN_SPLIT);
	assign init_entry = '{free: 1'b1, pay: eff - PAY_W'(HDR_BYTES)};

	// Request size rounding.
	logic [32:0]      rnd;
	assign rnd = {1'b0, s_axis_tdata[31:0]} + 33'd3;

	// Search pass.
	logic [31:0] head_addr;
	assign head_addr = run_q + 32'(HDR_BYTES);

	// Decision after the search pass.
	logic             alloc_path, dec_mod;
	logic [1:0]       dec_sts;
	logic [31:0]      dec_res, dec_old;
	logic [PAY_W-1:0] dec_copy;
	logic             dec_split, dec_use, dec_free, dec_coal;
	logic [CNT_W-1:0] dec_split_idx;

	always_comb begin
		alloc_path    = (act_q == ACT_ALLOC) || (act_q == ACT_RESIZE && addr_q == '0);
		dec_sts       = STS_OK;
		dec_res       = '0;
		dec_old       = '0;
		dec_copy      = '0;
		dec_split     = 1'b0;
		dec_use       = 1'b0;
		dec_free      = 1'b0;
		dec_coal      = 1'b0;
		dec_split_idx = n_idx_q;
		if (alloc_path) begin
			if (req_q == '0) begin
				dec_sts = STS_ZERO;
			end else if (!r_ok_q || !fn_q) begin
				dec_sts = STS_NOSPACE;
			end else begin
				dec_split = 1'b1;
				dec_use   = 1'b1;
				dec_res   = n_addr_q;
			end
		end else if (act_q != ACT_RELEASE && act_q != ACT_RESIZE) begin
			dec_sts = STS_BADADDR;
		end else if (act_q == ACT_RELEASE && addr_q == '0) begin
			dec_sts = STS_OK;
		end else if (!fo_q) begin
			dec_sts = STS_BADADDR;
		end else if (act_q == ACT_RELEASE) begin
			dec_free = 1'b1;
			dec_coal = 1'b1;
		end else if (req_q == '0) begin
			dec_free = 1'b1;
			dec_coal = 1'b1;
			dec_sts  = STS_ZERO;
		end else if (!r_ok_q) begin
			dec_sts = STS_NOSPACE;
		end else if (o_pay_q >= r_q) begin
			// Shrink or keep in place.
			dec_split     = 1'b1;
			dec_split_idx = o_idx_q;
			dec_res       = addr_q;
		end else if (!fn_q) begin
			dec_sts = STS_NOSPACE;
		end else begin
			// Move: grant a new block, free the old one and report the copy.
			dec_split = 1'b1;
			dec_use   = 1'b1;
			dec_free  = 1'b1;
			dec_coal  = 1'b1;
			dec_res   = n_addr_q;
			dec_copy  = o_pay_q;
			dec_old   = addr_q;
		end
		dec_mod = dec_split || dec_use || dec_free;
	end

	// Rewrite pass: transform the head entry, then merge it into the accumulator.
	logic             free_p, split_here, merge, mod_pop, mod_last;
	entry_t           prod, acc_n;
	logic [PAY_W-1:0] rem_n;
	logic [CNT_W-1:0] k_next;

	always_comb begin
		if (do_use_q && k_q == n_idx_q) begin
			free_p = 1'b0;
		end else if (do_free_q && k_q == o_idx_q) begin
			free_p = 1'b1;
		end else begin
			free_p = head.free;
		end
		split_here = !pend_q && do_split_q && (k_q == split_idx_q)
			&& (n_blk_q < CNT_W'(MAX_BLOCKS))
			&& ((PAY_W+1)'(head.pay) >= (PAY_W+1)'(r_q) + (PAY_W+1)'(MIN_SPLIT));
		rem_n = head.pay - r_q - PAY_W'(HDR_BYTES);
		if (pend_q) begin
			prod = '{free: 1'b1, pay: rem_q};
		end else begin
			prod = '{free: free_p, pay: split_here ? r_q : head.pay};
		end
		merge = coal_q && acc_v_q && acc_q.free && prod.free;
		if (merge) begin
			acc_n = '{free: 1'b1, pay: acc_q.pay + PAY_W'(HDR_BYTES) + prod.pay};
		end else begin
			acc_n = prod;
		end
		mod_pop  = !pend_q;
		k_next   = k_q + CNT_W'(mod_pop);
		mod_last = !split_here && (k_next == n_blk_q);
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_INIT: state_n = S_IDLE;
			S_IDLE: begin
				if (cfg_fire) begin
					state_n = S_INIT;
				end else if (in_fire) begin
					state_n = (count != '0) ? S_SCAN : S_DECIDE;
				end
			end
			S_SCAN: begin
				if (k_q == n_blk_q - CNT_W'(1)) begin
					state_n = S_DECIDE;
				end
			end
			S_DECIDE: state_n = dec_mod ? S_MOD : S_DONE;
			S_MOD: begin
				if (mod_last) begin
					state_n = S_FLUSH;
				end
			end
			S_FLUSH: state_n = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_INIT;
		endcase
	end

	// Table control.
	always_comb begin
		ctl       = '0;
		push_data = acc_q;
		case (state_q)
			S_INIT: begin
				ctl.clear = 1'b1;
				ctl.push  = init_ok;
				push_data = init_entry;
			end
			S_SCAN: begin
				ctl.pop   = 1'b1;
				ctl.push  = 1'b1;
				push_data = head;
			end
			S_MOD: begin
				ctl.pop  = mod_pop;
				ctl.push = acc_v_q && !merge;
			end
			S_FLUSH: ctl.push = acc_v_q;
			default: ctl = '0;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			heap_base_q  <= '0;
			heap_bytes_q <= PAY_W'(65536);
			k_q          <= '0;
			fo_q         <= 1'b0;
			fn_q         <= 1'b0;
			do_split_q   <= 1'b0;
			do_use_q     <= 1'b0;
			do_free_q    <= 1'b0;
			coal_q       <= 1'b0;
			pend_q       <= 1'b0;
			acc_v_q      <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_fire) begin
				if (cfg_index) begin
					heap_bytes_q <= cfg_data[PAY_W-1:0];
				end else begin
					heap_base_q <= cfg_data;
				end
			end
			case (state_q)
				S_IDLE: begin
					k_q  <= '0;
					fo_q <= 1'b0;
					fn_q <= 1'b0;
				end
				S_SCAN: begin
					k_q <= k_q + CNT_W'(1);
					if (!fo_q && !head.free && head_addr == addr_q) begin
						fo_q <= 1'b1;
					end
					if (!fn_q && head.free && r_ok_q && head.pay >= r_q) begin
						fn_q <= 1'b1;
					end
				end
				S_DECIDE: begin
					k_q        <= '0;
					do_split_q <= dec_split;
					do_use_q   <= dec_use;
					do_free_q  <= dec_free;
					coal_q     <= dec_coal;
					pend_q     <= 1'b0;
					acc_v_q    <= 1'b0;
				end
				S_MOD: begin
					k_q     <= k_next;
					pend_q  <= split_here;
					acc_v_q <= 1'b1;
				end
				default: ;
			endcase
			if (state_q == S_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Data registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_INIT: origin_q <= heap_base_q + 32'(adj);
			S_IDLE: begin
				act_q   <= s_axis_tuser;
				req_q   <= s_axis_tdata[31:0];
				addr_q  <= s_axis_tdata[63:32];
				r_q     <= {rnd[PAY_W-1:2], 2'b00};
				r_ok_q  <= (rnd[32:PAY_W] == '0);
				n_blk_q <= count;
				run_q   <= origin_q;
			end
			S_SCAN: begin
				run_q <= run_q + 32'(HDR_BYTES) + 32'(head.pay);
				if (!fo_q && !head.free && head_addr == addr_q) begin
					o_idx_q <= k_q;
					o_pay_q <= head.pay;
				end
				if (!fn_q && head.free && r_ok_q && head.pay >= r_q) begin
					n_idx_q  <= k_q;
					n_addr_q <= head_addr;
				end
			end
			S_DECIDE: begin
				sts_q       <= dec_sts;
				res_q       <= dec_res;
				copy_q      <= dec_copy;
				old_q       <= dec_old;
				split_idx_q <= dec_split_idx;
			end
			S_MOD: begin
				acc_q <= acc_n;
				if (split_here) begin
					rem_q <= rem_n;
				end
			end
			S_DONE: begin
				if (out_free) begin
					m_user_q <= sts_q;
					m_data_q <= {4'b0000, old_q, copy_q, res_q};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tdata  = m_data_q;
endmodule

FILE: hdl/ffha_checker.sv
// Port-level checks of the first-fit heap allocator, bound to the top level.
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker import ffha_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [87:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        cfg_valid,
	input logic        cfg_ready
);
	logic [31:0] res_addr;
	logic [19:0] copy_bytes;
	logic [31:0] old_addr;
	logic        copy_bad;
	logic        both_fire;

	assign res_addr   = m_axis_tdata[31:0];
	assign copy_bytes = m_axis_tdata[51:32];
	assign old_addr   = m_axis_tdata[83:52];
	// A copy is only reported by a successful move, which always names its source.
	assign copy_bad   = (copy_bytes != 20'd0) && (m_axis_tuser != STS_OK || old_addr == 32'd0);
	assign both_fire  = s_axis_tvalid && s_axis_tready && cfg_valid && cfg_ready;

	`FFHA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
	`FFHA_NEVER(a_nospace_addr, m_axis_tvalid && m_axis_tuser == STS_NOSPACE && res_addr != 32'd0, "address granted with no space")
	`FFHA_NEVER(a_copy_ok, m_axis_tvalid && copy_bad, "copy without a move")
	`FFHA_NEVER(a_one_side, both_fire, "request and register write taken together")
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

FILE: bench/first_fit_heap_allocator_test.sv
// Self-checking stream testbench for the first-fit heap allocator.
module first_fit_heap_allocator_test import ffha_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_CYCLES = 600;
	localparam logic CFG_BASE = 1'b0;
	localparam logic CFG_BYTES = 1'b1;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] req_bytes;
		logic [31:0] address;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_address;
		logic [19:0] copy_bytes;
		logic [31:0] old_address;
	} reply_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [87:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [31:0] cfg_data;

	first_fit_heap_allocator dut (.*);

	// Shadow heap state.
	logic [31:0] base_reg;
	logic [19:0] bytes_reg;
	logic [31:0] origin;
	logic [19:0] pay_tab[MAX_BLOCKS];
	logic free_tab[MAX_BLOCKS];
	int n_blocks;

	request_t pending_requests[$];
	reply_t expected_replies[$];
	logic [31:0] live_addrs[$];
	int sender_idle_pct;
	int receiver_idle_pct;
	int hold_requests = 0;
	int hold_seen;
	int hold_left;
	int mismatches = 0;
	longint cycles = 0;

	function automatic void rebuild_heap();
		logic [31:0] adj;
		logic [31:0] eff;
		adj = (32'd4 - {30'd0, base_reg[1:0]}) & 32'd3;
		eff = ({12'd0, bytes_reg} >= adj) ? (({12'd0, bytes_reg} - adj) & ~32'd3) : 32'd0;
		origin = base_reg + adj;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			pay_tab[i] = '0;
			free_tab[i] = 1'b0;
		end
		if (eff >= MIN_SPLIT) begin
			pay_tab[0] = 20'(eff - HDR_BYTES);
			free_tab[0] = 1'b1;
			n_blocks = 1;
		end else begin
			n_blocks = 0;
		end
	endfunction

	function automatic logic [31:0] block_addr(int idx);
		logic [31:0] a;
		a = origin;
		for (int j = 0; j < idx; j++)
			a += HDR_BYTES + {12'd0, pay_tab[j]};
		return a + HDR_BYTES;
	endfunction

	function automatic int find_block(logic [31:0] a);
		for (int i = 0; i < n_blocks; i++)
			if (!free_tab[i] && block_addr(i) == a)
				return i;
		return -1;
	endfunction

	function automatic void split_at(int i, logic [20:0] r);
		if (n_blocks < MAX_BLOCKS && {1'b0, pay_tab[i]} >= r + MIN_SPLIT) begin
			for (int k = n_blocks; k > i + 1; k--) begin
				pay_tab[k] = pay_tab[k-1];
				free_tab[k] = free_tab[k-1];
			end
			pay_tab[i+1] = pay_tab[i] - r[19:0] - 20'(HDR_BYTES);
			free_tab[i+1] = 1'b1;
			pay_tab[i] = r[19:0];
			n_blocks++;
		end
	endfunction

	function automatic int first_fit(logic [20:0] r);
		for (int i = 0; i < n_blocks; i++)
			if (free_tab[i] && {1'b0, pay_tab[i]} >= r) begin
				split_at(i, r);
				free_tab[i] = 1'b0;
				return i;
			end
		return -1;
	endfunction

	function automatic void merge_free();
		int w;
		w = 0;
		for (int i = 0; i < n_blocks; i++) begin
			if (w > 0 && free_tab[w-1] && free_tab[i]) begin
				pay_tab[w-1] += 20'(HDR_BYTES) + pay_tab[i];
			end else begin
				pay_tab[w] = pay_tab[i];
				free_tab[w] = free_tab[i];
				w++;
			end
		end
		for (int i = w; i < n_blocks; i++) begin
			pay_tab[i] = '0;
			free_tab[i] = 1'b0;
		end
		n_blocks = w;
	endfunction

	// Rounded size, or zero when it does not fit the payload width.
	function automatic logic [20:0] round_size(logic [31:0] req);
		logic [32:0] r;
		r = ({1'b0, req} + 33'd3) & ~33'd3;
		return (r[32:20] != 0) ? 21'd0 : r[20:0];
	endfunction

	function automatic reply_t predict_reply(request_t q);
		reply_t y;
		logic [20:0] r;
		int o;
		int n;
		int cnt0;
		y = '0;
		if (q.action == ACT_ALLOC || (q.action == ACT_RESIZE && q.address == 0)) begin
			if (q.req_bytes == 0) begin
				y.status = STS_ZERO;
			end else begin
				r = round_size(q.req_bytes);
				n = (r != 0) ? first_fit(r) : -1;
				if (n < 0) y.status = STS_NOSPACE;
				else y.result_address = block_addr(n);
			end
			return y;
		end
		if (q.action == ACT_UNUSED) begin
			y.status = STS_BADADDR;
			return y;
		end
		if (q.address == 0) return y;
		o = find_block(q.address);
		if (o < 0) begin
			y.status = STS_BADADDR;
			return y;
		end
		if (q.action == ACT_RELEASE || q.req_bytes == 0) begin
			free_tab[o] = 1'b1;
			merge_free();
			if (q.action == ACT_RESIZE) y.status = STS_ZERO;
			return y;
		end
		r = round_size(q.req_bytes);
		if (r == 0) begin
			y.status = STS_NOSPACE;
			return y;
		end
		if ({1'b0, pay_tab[o]} >= r) begin
			split_at(o, r);
			y.result_address = q.address;
			return y;
		end
		cnt0 = n_blocks;
		n = first_fit(r);
		if (n < 0) begin
			y.status = STS_NOSPACE;
			return y;
		end
		if (n_blocks > cnt0 && n < o) o++;
		y.result_address = block_addr(n);
		y.copy_bytes = pay_tab[o];
		y.old_address = q.address;
		free_tab[o] = 1'b1;
		merge_free();
		return y;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: offers queued requests, predicting each one as it transfers.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_replies.push_back(predict_reply(pending_requests.pop_front()));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_requests.size() != 0 &&
				    $urandom_range(99) >= sender_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {pending_requests[0].address, pending_requests[0].req_bytes};
					s_axis_tuser <= pending_requests[0].action;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver stalls, including a long hold-off counted here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Monitor.
	always @(posedge clk) begin
		reply_t got;
		reply_t exp;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser;
			got.result_address = m_axis_tdata[31:0];
			got.copy_bytes = m_axis_tdata[51:32];
			got.old_address = m_axis_tdata[83:52];
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected transfer, actual %h", $time, got);
				mismatches++;
			end else begin
				exp = expected_replies.pop_front();
				if (got.status !== exp.status)
					$display("%0t: status expected %0d actual %0d", $time, exp.status,
						got.status);
				if (got.result_address !== exp.result_address)
					$display("%0t: result_address expected %h actual %h", $time,
						exp.result_address, got.result_address);
				if (got.copy_bytes !== exp.copy_bytes)
					$display("%0t: copy_bytes expected %h actual %h", $time,
						exp.copy_bytes, got.copy_bytes);
				if (got.old_address !== exp.old_address)
					$display("%0t: old_address expected %h actual %h", $time,
						exp.old_address, got.old_address);
				if (got !== exp) mismatches++;
				else if (exp.status == STS_OK && exp.result_address != 0)
					live_addrs.push_back(exp.result_address);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_requests.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_BASE) base_reg = value;
		else bytes_reg = value[19:0];
		rebuild_heap();
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_address();
		int k;
		case ($urandom_range(9))
			0: return 32'd0;
			1: return $urandom();
			2: return origin + 4 * $urandom_range(64);
			default: begin
				if (live_addrs.size() == 0) return $urandom();
				k = $urandom_range(live_addrs.size() - 1);
				pick_address = live_addrs[k];
				live_addrs.delete(k);
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_size();
		case ($urandom_range(19))
			0: return $urandom();
			1: return 32'd0;
			2: return $urandom_range(20000);
			default: return $urandom_range(600);
		endcase
	endfunction

	// Requests are generated lazily so that addresses follow the grants seen.
	task automatic run_random(int count);
		request_t q;
		for (int i = 0; i < count; i++) begin
			while (pending_requests.size() > 2) @(posedge clk);
			q.action = ($urandom_range(49) == 0) ? ACT_UNUSED : 2'($urandom_range(2));
			q.req_bytes = pick_size();
			q.address = (q.action == ACT_ALLOC) ? $urandom() : pick_address();
			pending_requests.push_back(q);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BASE;
		cfg_data = '0;
		sender_idle_pct = 10;
		receiver_idle_pct = 77;
		base_reg = '0;
		bytes_reg = 20'd65536;
		rebuild_heap();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: extremes, every action and the special cases.
		pending_requests.push_back('{ACT_ALLOC, 32'd0, 32'd0});
		pending_requests.push_back('{ACT_ALLOC, 32'd1, 32'hFFFF_FFFF});
		pending_requests.push_back('{ACT_ALLOC, 32'hFFFF_FFFF, 32'd0});
		pending_requests.push_back('{ACT_ALLOC, 32'h000F_FFFD, 32'd0});
		pending_requests.push_back('{ACT_ALLOC, 32'd100, 32'd0});
		pending_requests.push_back('{ACT_RELEASE, 32'd0, 32'd0});
		pending_requests.push_back('{ACT_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		pending_requests.push_back('{ACT_RESIZE, 32'd0, 32'd0});
		pending_requests.push_back('{ACT_RESIZE, 32'd40, 32'd0});
		pending_requests.push_back('{ACT_RESIZE, 32'd8, 32'd24});
		pending_requests.push_back('{ACT_RESIZE, 32'd400, 32'd24});
		pending_requests.push_back('{ACT_RESIZE, 32'hFFFF_FFFF, 32'd12});
		pending_requests.push_back('{ACT_RESIZE, 32'd0, 32'd12});
		pending_requests.push_back('{ACT_UNUSED, 32'd5, 32'd12});
		pending_requests.push_back('{ACT_RELEASE, 32'd0, 32'd24});
		pending_requests.push_back('{ACT_ALLOC, 32'd70000, 32'd0});
		wait_idle();

		// Fill the table so blocks are granted whole.
		live_addrs.delete();
		for (int i = 0; i < 70; i++)
			pending_requests.push_back('{ACT_ALLOC, 32'd4, 32'd0});
		wait_idle();
		run_random(100);
		wait_idle();

		// Long receiver hold-off while the sender keeps offering.
		sender_idle_pct = 0;
		hold_requests++;
		run_random(30);
		wait_idle();

		write_reg(CFG_BASE, 32'hFFFF_FFF1);
		write_reg(CFG_BYTES, 32'd2000);
		live_addrs.delete();
		sender_idle_pct = 77;
		receiver_idle_pct = 10;
		run_random(300);
		wait_idle();

		write_reg(CFG_BYTES, 32'd18);
		live_addrs.delete();
		run_random(15);
		wait_idle();

		write_reg(CFG_BASE, 32'h0000_0002);
		write_reg(CFG_BYTES, 32'hFFFF_FFFF);
		live_addrs.delete();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		run_random(300);
		wait_idle();

		write_reg(CFG_BASE, 32'd0);
		write_reg(CFG_BYTES, 32'd16);
		live_addrs.delete();
		run_random(10);
		wait_idle();
		write_reg(CFG_BYTES, 32'd4000);
		live_addrs.delete();
		run_random(300);
		wait_idle();

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
